// ===== design/lnp_pkg.sv =====
// shared types and constants for the lexicographic next-permutation engine
// no dependencies; imported by every module of the block

package lnp_pkg;

   localparam int MODE_W  = 2;
   localparam int INDEX_W = 7;
   localparam int ELEM_W  = 8;
   localparam int LEN_W   = 8;

   localparam logic [LEN_W-1:0] LEN_RESET = 8'd128;

   // request modes
   localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_J_SCAN,
      ST_L_SCAN,
      ST_SWAP_J,
      ST_REV_B,
      ST_REV_C,
      ST_REV_D
   } lnp_state_type;

   typedef struct packed {
      logic              advanced;
      logic [ELEM_W-1:0] read_value;
   } lnp_result_type;

endpackage

// ===== design/lnp_if.sv =====
// request and response channel interfaces
// depends on lnp_pkg for field widths

interface lnp_req_if;
   import lnp_pkg::*;
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [INDEX_W-1:0] elem_index;
   logic [ELEM_W-1:0]  elem_value;

   modport source (output valid, output mode, output elem_index, output elem_value,
                   input ready);
   modport sink   (input valid, input mode, input elem_index, input elem_value,
                   output ready);
endinterface

interface lnp_rsp_if;
   import lnp_pkg::*;
   logic              valid;
   logic              ready;
   logic              advanced;
   logic [ELEM_W-1:0] read_value;

   modport source (output valid, output advanced, output read_value, input ready);
   modport sink   (input valid, input advanced, input read_value, output ready);
endinterface

// ===== design/lnp_store.sv =====
// element store: one write port, one registered read port, clearing pass after reset
// depends on lnp_pkg

module lnp_store
   import lnp_pkg::*;
#(
   parameter int MAX_LEN = 128,
   parameter int AW      = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [ELEM_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [ELEM_W-1:0] wr_data,
   output logic              clr_busy
);

   logic [ELEM_W-1:0] mem [MAX_LEN];
   logic [ELEM_W-1:0] rdata_ff;
   logic [AW-1:0]     clr_ptr_ff, clr_ptr_in;
   logic              busy_ff, busy_in;
   logic              we;
   logic [AW-1:0]     waddr;
   logic [ELEM_W-1:0] wdata;

   always_comb begin
      clr_ptr_in = clr_ptr_ff;
      busy_in    = busy_ff;
      if (busy_ff) begin
         if (clr_ptr_ff == AW'(MAX_LEN - 1)) begin
            busy_in = 1'b0;
         end else begin
            clr_ptr_in = clr_ptr_ff + AW'(1);
         end
      end
      we    = busy_ff ? 1'b1 : wr_en;
      waddr = busy_ff ? clr_ptr_ff : wr_addr;
      wdata = busy_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_ptr_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         clr_ptr_ff <= clr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rdata_ff;
   assign clr_busy = busy_ff;

   a_clear_ends_at_top: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(clr_ptr_ff) == AW'(MAX_LEN - 1))
      else $error("clearing pass ended early");

   a_no_clear_after_done: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |=> !busy_ff)
      else $error("clearing pass restarted without reset");

   a_clear_from_zero: assert property (@(posedge clock)
      $fell(reset) |-> busy_ff && clr_ptr_ff == '0)
      else $error("clearing pass not started from entry zero");

endmodule

// ===== design/lnp_resp.sv =====
// response output register with a one-deep holding slot
// depends on lnp_pkg and lnp_rsp_if

module lnp_resp
   import lnp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           res_valid,
   input  lnp_result_type res,
   output logic           slot_free,
   lnp_rsp_if.source      rsp_ch
);

   logic           out_valid_ff, out_valid_in;
   lnp_result_type out_ff, out_in;
   logic           pend_valid_ff, pend_valid_in;
   lnp_result_type pend_ff, pend_in;
   logic           out_free;

   always_comb begin
      out_free      = !out_valid_ff || rsp_ch.ready;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_in        = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (pend_valid_ff && out_free) begin
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         pend_valid_in = 1'b0;
      end
      if (res_valid) begin
         if (out_free && !pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = res;
         end else begin
            pend_valid_in = 1'b1;
            pend_in       = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign slot_free         = !pend_valid_ff;
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.advanced   = out_ff.advanced;
   assign rsp_ch.read_value = out_ff.read_value;

   a_pend_needs_out: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> out_valid_ff)
      else $error("held beat without a beat in the output register");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !pend_valid_ff)
      else $error("result arrived while holding slot full");

   a_pend_moves: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff && rsp_ch.ready |=> !pend_valid_ff)
      else $error("held beat not moved forward");

endmodule

// ===== design/lnp_seq.sv =====
// sequencer: load, read and the next-permutation step over the element store
// depends on lnp_pkg and lnp_req_if

module lnp_seq
   import lnp_pkg::*;
#(
   parameter int MAX_LEN = 128,
   parameter int AW      = 7
) (
   input  logic              clock,
   input  logic              reset,
   lnp_req_if.sink           req_ch,
   input  logic              csr_we,
   input  logic [LEN_W-1:0]  csr_wdata,
   input  logic              clr_busy,
   input  logic              slot_free,
   output logic              rd_en,
   output logic [AW-1:0]     rd_addr,
   input  logic [ELEM_W-1:0] rd_data,
   output logic              wr_en,
   output logic [AW-1:0]     wr_addr,
   output logic [ELEM_W-1:0] wr_data,
   output logic              res_valid,
   output lnp_result_type    res
);

   localparam int CW = (AW > LEN_W) ? AW + 1 : LEN_W + 1;

   lnp_state_type state_ff, state_in;
   logic [LEN_W-1:0]  len_ff;
   logic [AW-1:0]     cur_ff, cur_in;
   logic [AW-1:0]     last_ff, last_in;
   logic [AW-1:0]     j_ff, j_in;
   logic [AW-1:0]     lo_ff, lo_in;
   logic [AW-1:0]     hi_ff, hi_in;
   logic [ELEM_W-1:0] prev_ff, prev_in;
   logic [ELEM_W-1:0] vj_ff, vj_in;
   logic [ELEM_W-1:0] vl_ff, vl_in;
   logic [ELEM_W-1:0] lov_ff, lov_in;
   logic              have_prev_ff, have_prev_in;
   logic              rd_ok_ff, rd_ok_in;

   logic [CW-1:0] len_w, max_w, n_w, last_w, idx_w;
   logic          idx_ok;
   logic [AW-1:0] idx_addr, last_c, j_next;
   logic [AW:0]   lo_p2;
   logic          accept;

   always_comb begin
      len_w    = CW'(len_ff);
      max_w    = CW'(MAX_LEN);
      n_w      = (len_w > max_w) ? max_w : len_w;
      last_w   = n_w - CW'(1);
      last_c   = last_w[AW-1:0];
      idx_w    = CW'(req_ch.elem_index);
      idx_ok   = idx_w < max_w;
      idx_addr = idx_w[AW-1:0];
      j_next   = j_ff + AW'(1);
      lo_p2    = {1'b0, lo_ff} + (AW+1)'(2);
   end

   assign req_ch.ready = (state_ff == ST_IDLE) && !clr_busy && slot_free;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      j_in         = j_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      prev_in      = prev_ff;
      vj_in        = vj_ff;
      vl_in        = vl_ff;
      lov_in       = lov_ff;
      have_prev_in = have_prev_ff;
      rd_ok_in     = rd_ok_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      res_valid    = 1'b0;
      res          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_ch.mode)
                  MODE_LOAD: begin
                     wr_en     = idx_ok;
                     wr_addr   = idx_addr;
                     wr_data   = req_ch.elem_value;
                     res_valid = 1'b1;
                  end
                  MODE_ADVANCE: begin
                     if (n_w < CW'(2)) begin
                        res_valid = 1'b1;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = last_c;
                        cur_in       = last_c;
                        last_in      = last_c;
                        have_prev_in = 1'b0;
                        state_in     = ST_J_SCAN;
                     end
                  end
                  MODE_READ: begin
                     rd_en    = idx_ok;
                     rd_addr  = idx_addr;
                     rd_ok_in = idx_ok;
                     state_in = ST_RD_WAIT;
                  end
                  default: begin
                     res_valid = 1'b1;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            res_valid      = 1'b1;
            res.read_value = rd_ok_ff ? rd_data : '0;
            state_in       = ST_IDLE;
         end
         ST_J_SCAN: begin
            if (have_prev_ff && (rd_data < prev_ff)) begin
               j_in     = cur_ff;
               vj_in    = rd_data;
               rd_en    = 1'b1;
               rd_addr  = last_ff;
               cur_in   = last_ff;
               state_in = ST_L_SCAN;
            end else if (cur_ff == '0) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               prev_in      = rd_data;
               have_prev_in = 1'b1;
               rd_en        = 1'b1;
               rd_addr      = cur_ff - AW'(1);
               cur_in       = cur_ff - AW'(1);
            end
         end
         ST_L_SCAN: begin
            if ((rd_data > vj_ff) || (cur_ff == j_next)) begin
               wr_en    = 1'b1;
               wr_addr  = cur_ff;
               wr_data  = vj_ff;
               vl_in    = rd_data;
               state_in = ST_SWAP_J;
            end else begin
               rd_en   = 1'b1;
               rd_addr = cur_ff - AW'(1);
               cur_in  = cur_ff - AW'(1);
            end
         end
         ST_SWAP_J: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = vl_ff;
            if (j_next < last_ff) begin
               rd_en    = 1'b1;
               rd_addr  = j_next;
               lo_in    = j_next;
               hi_in    = last_ff;
               state_in = ST_REV_B;
            end else begin
               res_valid    = 1'b1;
               res.advanced = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_REV_B: begin
            lov_in   = rd_data;
            rd_en    = 1'b1;
            rd_addr  = hi_ff;
            state_in = ST_REV_C;
         end
         ST_REV_C: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff;
            wr_data  = rd_data;
            state_in = ST_REV_D;
         end
         ST_REV_D: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = lov_ff;
            if (lo_p2 < {1'b0, hi_ff}) begin
               rd_en    = 1'b1;
               rd_addr  = lo_ff + AW'(1);
               lo_in    = lo_ff + AW'(1);
               hi_in    = hi_ff - AW'(1);
               state_in = ST_REV_B;
            end else begin
               res_valid    = 1'b1;
               res.advanced = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= LEN_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            len_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      last_ff      <= last_in;
      j_ff         <= j_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      prev_ff      <= prev_in;
      vj_ff        <= vj_in;
      vl_ff        <= vl_in;
      lov_ff       <= lov_in;
      have_prev_ff <= have_prev_in;
      rd_ok_ff     <= rd_ok_in;
   end

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr_en |-> rd_addr != wr_addr)
      else $error("read and write of the same entry in one cycle");

   a_partner_right_of_j: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_L_SCAN |-> cur_ff > j_ff)
      else $error("swap partner search passed the ascent");

   a_reverse_ordered: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REV_B |-> lo_ff < hi_ff)
      else $error("suffix reversal pointers crossed");

   a_idle_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> state_ff == ST_IDLE && !req_ch.ready)
      else $error("work started during clearing pass");

endmodule

// ===== design/lexicographic_next_permutation.sv =====
// top level of the lexicographic next-permutation engine
// depends on lnp_pkg, lnp_if, lnp_store, lnp_seq and lnp_resp
//
//  channel   dir  handshake          payload
//  req_ch    in   valid / ready      mode, elem_index, elem_value
//  rsp_ch    out  valid / ready      advanced, read_value
//  csr       in   csr_we             csr_wdata (length_in_use)
//
// load and unused-mode beats finish in the accept cycle, read beats in the cycle after
// an advance on a length below two finishes in the accept cycle; otherwise it scans for
// the rightmost ascent and ends there if there is none, else it scans for the swap
// partner, swaps the two and reverses the suffix; the element store has one read and
// one write port, one read and one write per cycle
// after reset a clearing pass zeroes the store; no request is taken until it ends,
// configuration writes are taken throughout
// one request is worked at a time; the next is taken while its response waits in
// the output register, and the engine stalls only when a second response is held

module lexicographic_next_permutation
   import lnp_pkg::*;
#(
   parameter int MAX_LEN = 128
) (
   input  logic             clock,
   input  logic             reset,
   lnp_req_if.sink          req_ch,
   lnp_rsp_if.source        rsp_ch,
   input  logic             csr_we,
   input  logic [LEN_W-1:0] csr_wdata
);

   // store address width
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   // store ports
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [ELEM_W-1:0] rd_data;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [ELEM_W-1:0] wr_data;
   logic              clr_busy;

   // sequencer to response stage
   logic              res_valid;
   lnp_result_type    res;
   logic              slot_free;

   // element store, zeroed after reset
   lnp_store #(
      .MAX_LEN (MAX_LEN),
      .AW      (AW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .clr_busy (clr_busy)
   );

   // request decode, ascent scan, partner scan, swap and suffix reversal
   lnp_seq #(
      .MAX_LEN (MAX_LEN),
      .AW      (AW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .clr_busy  (clr_busy),
      .slot_free (slot_free),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .res_valid (res_valid),
      .res       (res)
   );

   // output register and holding slot
   lnp_resp u_resp (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .slot_free (slot_free),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== dv/tb.sv =====
// self-checking bench for the lexicographic next-permutation engine
// depends on lnp_pkg, lnp_if and the lexicographic_next_permutation top level
// a shadow store predicts every response beat; directed beats first, then random phases
`timescale 1ns / 100ps

module tb;
   import lnp_pkg::*;

   localparam int STORE_DEPTH   = 128;
   localparam int SETTLE_CYCLES = 16;   // idle gap before a length write
   localparam int END_CYCLES    = 500;  // longer than the slowest advance
   localparam int HOLD_CYCLES   = 400;  // long receiver hold-off
   localparam int RANDOM_ITEMS  = 1000;

   // the spare request code, no action in the block
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   typedef struct {
      logic [MODE_W-1:0]  mode;
      logic [INDEX_W-1:0] idx;
      logic [ELEM_W-1:0]  val;
   } lnp_req_beat_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [LEN_W-1:0] csr_wdata;

   lnp_req_if req_bus ();
   lnp_rsp_if rsp_bus ();

   lexicographic_next_permutation #(
      .MAX_LEN (STORE_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the element store and the length register
   logic [ELEM_W-1:0] vec_shadow [STORE_DEPTH];
   logic [LEN_W-1:0]  len_shadow;

   lnp_req_beat_type req_backlog [$];  // beats still to be offered
   lnp_result_type   due_rsp [$];      // responses owed by the block, oldest first

   int  err_count     = 0;
   int  sent_total    = 0;
   int  send_idle_pct = 0;
   int  stall_pct     = 0;
   logic req_beat     = 1'b0;
   logic hold_on      = 1'b0;
   logic hold_over    = 1'b0;

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      err_count++;
   endtask

   // one request against the shadow store, giving the response it must cause
   function automatic lnp_result_type permute_step(lnp_req_beat_type b);
      lnp_result_type r;
      int n, j, l, lo, hi;
      logic [ELEM_W-1:0] t;
      r = '0;
      case (b.mode)
         MODE_LOAD: vec_shadow[b.idx] = b.val;
         MODE_READ: r.read_value = vec_shadow[b.idx];
         MODE_ADVANCE: begin
            // lengths past the store saturate
            n = (int'(len_shadow) > STORE_DEPTH) ? STORE_DEPTH : int'(len_shadow);
            // rightmost ascent; none for lengths below two or a non-increasing vector
            j = n - 2;
            while (j >= 0 && vec_shadow[j] >= vec_shadow[j + 1])
               j--;
            if (j >= 0) begin
               // rightmost entry larger than the ascent head
               l = n - 1;
               while (l > j + 1 && vec_shadow[l] <= vec_shadow[j])
                  l--;
               t = vec_shadow[j];
               vec_shadow[j] = vec_shadow[l];
               vec_shadow[l] = t;
               // reverse the tail after the ascent
               lo = j + 1;
               hi = n - 1;
               while (lo < hi) begin
                  t = vec_shadow[lo];
                  vec_shadow[lo] = vec_shadow[hi];
                  vec_shadow[hi] = t;
                  lo++;
                  hi--;
               end
               r.advanced = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // response check first, then prediction of the request beat taken at this edge
   always @(posedge clock) begin : monitor
      lnp_result_type   want;
      lnp_req_beat_type taken;
      req_beat <= !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_rsp.size() == 0) begin
               report_mismatch("response beat with nothing owed",
                               int'(rsp_bus.read_value), 0);
            end else begin
               want = due_rsp.pop_front();
               if (rsp_bus.advanced !== want.advanced)
                  report_mismatch("advanced", int'(rsp_bus.advanced),
                                  int'(want.advanced));
               if (rsp_bus.read_value !== want.read_value)
                  report_mismatch("read_value", int'(rsp_bus.read_value),
                                  int'(want.read_value));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            taken.mode = req_bus.mode;
            taken.idx  = req_bus.elem_index;
            taken.val  = req_bus.elem_value;
            due_rsp.push_back(permute_step(taken));
         end
      end
   end

   // request driver: a beat stays up until taken, gaps only between beats
   always @(negedge clock) begin : driver
      lnp_req_beat_type b;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_beat) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            b = req_backlog.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.mode       <= b.mode;
            req_bus.elem_index <= b.idx;
            req_bus.elem_value <= b.val;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response ready, held low throughout the hold-off stretch
   always @(negedge clock) begin
      rsp_bus.ready <= !reset && !(hold_on && !hold_over) &&
                       ($urandom_range(99) >= stall_pct);
   end

   // hold-off length counted here, apart from the stimulus
   initial begin : hold_off_timer
      wait (hold_on);
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_over = 1'b1;
   end

   initial begin : watchdog
      #40_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_item(logic [MODE_W-1:0] m, int idx, int val);
      lnp_req_beat_type b;
      b.mode = m;
      b.idx  = INDEX_W'(idx);
      b.val  = ELEM_W'(val);
      req_backlog.push_back(b);
      sent_total++;
   endtask

   // every owed beat back, then a short quiet gap
   task automatic wait_drain(int extra);
      while (req_backlog.size() != 0 || req_bus.valid || due_rsp.size() != 0)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // length register write, only with the block idle
   task automatic write_length(int v);
      wait_drain(SETTLE_CYCLES);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= LEN_W'(v);
      @(negedge clock);
      csr_we    <= 1'b0;
      len_shadow = LEN_W'(v);
      @(posedge clock);
   endtask

   task automatic set_idling(int sel);
      case (sel)
         0: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         1: begin
            send_idle_pct = 73;
            stall_pct     = 0;
         end
         2: begin
            send_idle_pct = 0;
            stall_pct     = 73;
         end
         default: begin
            send_idle_pct = 34;
            stall_pct     = 34;
         end
      endcase
   endtask

   // load the active vector, or its tail when it is long
   task automatic fill_vector(int n_eff);
      int last, first, vmax, i;
      last  = (n_eff < 2) ? 2 : n_eff;
      first = (last > 10) ? last - $urandom_range(10, 3) : 0;
      vmax  = ($urandom_range(1) == 1) ? 255 : $urandom_range(3, 1);
      if ($urandom_range(9) == 0) begin
         // non-increasing tail, so the next advance has little or nothing to do
         for (i = first; i < last; i++)
            send_item(MODE_LOAD, i, 255 - i);
      end else begin
         for (i = first; i < last; i++)
            send_item(MODE_LOAD, i, $urandom_range(vmax, 0));
      end
   endtask

   task automatic run_phase(int p);
      int len_cfg, n_eff, quota, start, k, ridx;
      case (p % 8)
         0: len_cfg = 128;
         1: len_cfg = $urandom_range(255, 129);
         2: len_cfg = $urandom_range(1, 0);
         3: len_cfg = $urandom_range(127, 8);
         default: len_cfg = $urandom_range(7, 2);
      endcase
      write_length(len_cfg);
      n_eff = (len_cfg > STORE_DEPTH) ? STORE_DEPTH : len_cfg;
      if (p == 4) begin
         // receiver holds off while beats keep coming, so the block backs up
         set_idling(0);
         hold_on = 1'b1;
      end else begin
         set_idling(p % 4);
      end
      quota = $urandom_range(90, 60);
      start = sent_total;
      while (sent_total - start < quota) begin
         if ($urandom_range(99) < 10) begin
            // noise, spare code included
            send_item(MODE_W'($urandom_range(3, 0)), $urandom_range(127, 0),
                      $urandom_range(255, 0));
         end else begin
            fill_vector(n_eff);
            k = $urandom_range(14, 1);
            repeat (k) begin
               send_item(MODE_ADVANCE, $urandom_range(127, 0), $urandom_range(255, 0));
               if ($urandom_range(1) == 1) begin
                  ridx = (n_eff > 0) ? $urandom_range(n_eff - 1, 0) : $urandom_range(127, 0);
                  send_item(MODE_READ, ridx, $urandom_range(255, 0));
               end
            end
         end
      end
   endtask

   initial begin : stimulus
      int p;
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.mode         = MODE_LOAD;
      req_bus.elem_index   = '0;
      req_bus.elem_value   = '0;
      rsp_bus.ready        = 1'b0;
      for (int i = 0; i < STORE_DEPTH; i++)
         vec_shadow[i] = '0;
      len_shadow = LEN_RESET;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: cleared store, full-length scan, extremes, spare code
      send_item(MODE_READ, 0, 0);
      send_item(MODE_READ, 127, 255);
      send_item(MODE_ADVANCE, 0, 0);          // all equal, no ascent over the whole store
      send_item(MODE_LOAD, 127, 255);
      send_item(MODE_LOAD, 126, 0);
      send_item(MODE_SPARE, 127, 255);        // no effect, zero response
      send_item(MODE_ADVANCE, 127, 255);
      send_item(MODE_READ, 126, 0);
      send_item(MODE_READ, 127, 0);
      send_item(MODE_ADVANCE, 0, 0);
      write_length(1);                        // single entry, nothing to permute
      send_item(MODE_ADVANCE, 0, 0);
      write_length(0);                        // empty vector
      send_item(MODE_ADVANCE, 0, 0);
      write_length(2);
      send_item(MODE_LOAD, 0, 3);
      send_item(MODE_LOAD, 1, 7);
      send_item(MODE_ADVANCE, 0, 0);
      send_item(MODE_ADVANCE, 0, 0);          // already the last one
      send_item(MODE_READ, 0, 0);
      send_item(MODE_READ, 1, 0);
      write_length(255);                      // saturates at the store depth
      send_item(MODE_ADVANCE, 0, 0);
      send_item(MODE_READ, 127, 0);
      write_length(129);
      send_item(MODE_ADVANCE, 0, 0);

      // random phases until enough beats have gone out
      sent_total = 0;
      p = 0;
      while (sent_total < RANDOM_ITEMS) begin
         run_phase(p);
         p++;
      end

      wait_drain(END_CYCLES);
      if (err_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
